// File: rtl/core/rpbt_pkg.sv
// Shared types and constants for the RGB pixel blend and tint unit.
package rpbt_pkg;

	localparam int PIX_W   = 24;
	localparam int CHAN_W  = 8;
	localparam int NUM_CH  = 3;
	localparam int LEVEL_W = 9;
	localparam int GAIN_W  = 16;
	localparam int SUM_W   = 10;
	localparam int MUL_A_W = SUM_W;
	localparam int PROD_W  = MUL_A_W + GAIN_W;
	localparam int ALU_W   = 11;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Fraction bits dropped after the multiply.
	localparam int GAIN_FRAC = 8;
	localparam int GREY_FRAC = 16;

	typedef enum logic [1:0] {
		MODE_BLEND  = 2'd0,
		MODE_BRIGHT = 2'd1,
		MODE_GAIN   = 2'd2,
		MODE_GREY   = 2'd3
	} op_mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OP_MODE    = 3'd0,
		REG_LEVEL      = 3'd1,
		REG_GAIN_RED   = 3'd2,
		REG_GAIN_GREEN = 3'd3,
		REG_GAIN_BLUE  = 3'd4
	} cfg_reg_t;

	localparam logic [GAIN_W-1:0] GAIN_ONE = 16'd256;

	// ceil(2^16 * k) for k = 3/10, 4/15, 19/30; exact floor over sum 0..765.
	localparam logic [GAIN_W-1:0] GREY_COEF [NUM_CH] = '{16'd19661, 16'd17477, 16'd41507};

	typedef struct packed {
		op_mode_t                   mode;
		logic signed [LEVEL_W-1:0]  level;
	} rpbt_ctrl_t;

endpackage

// File: rtl/core/rpbt_in_if.sv
// Input channel: source and destination pixel beat.
interface rpbt_in_if;
	logic                          valid;
	logic                          ready;
	logic [rpbt_pkg::PIX_W-1:0]    src_pixel;
	logic [rpbt_pkg::PIX_W-1:0]    dest_pixel;

	modport source (output valid, output src_pixel, output dest_pixel, input ready);
	modport sink (input valid, input src_pixel, input dest_pixel, output ready);
endinterface

// File: rtl/core/rpbt_out_if.sv
// Output channel: result pixel beat.
interface rpbt_out_if;
	logic                          valid;
	logic                          ready;
	logic [rpbt_pkg::PIX_W-1:0]    out_pixel;

	modport source (output valid, output out_pixel, input ready);
	modport sink (input valid, input out_pixel, output ready);
endinterface

// File: rtl/core/rpbt_cfg_if.sv
// Configuration write channel: register index and write data.
interface rpbt_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [rpbt_pkg::CFG_IDX_W-1:0]     index;
	logic [rpbt_pkg::CFG_DATA_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/rpbt_lane.sv
// One color channel lane: saturating add path and multiply path.
module rpbt_lane (
	input  logic                              clk,
	input  logic                              en,
	input  rpbt_pkg::rpbt_ctrl_t              ctrl,
	input  rpbt_pkg::op_mode_t                mode_s1,
	input  logic [rpbt_pkg::CHAN_W-1:0]       src,
	input  logic [rpbt_pkg::CHAN_W-1:0]       dst,
	input  logic [rpbt_pkg::SUM_W-1:0]        sum,
	input  logic [rpbt_pkg::GAIN_W-1:0]       gain,
	input  logic [rpbt_pkg::GAIN_W-1:0]       coef,
	output logic [rpbt_pkg::CHAN_W-1:0]       chan
);

	localparam int AW = rpbt_pkg::ALU_W;
	localparam int CW = rpbt_pkg::CHAN_W;
	localparam int GT_W = rpbt_pkg::PROD_W - rpbt_pkg::GAIN_FRAC;
	localparam int YT_W = rpbt_pkg::PROD_W - rpbt_pkg::GREY_FRAC;

	logic signed [AW-1:0]             lvl_x;
	logic signed [AW-1:0]             src_x;
	logic signed [AW-1:0]             dst_x;
	logic signed [AW-1:0]             sub_w;
	logic signed [AW-1:0]             sub_pos_w;
	logic signed [AW-1:0]             add_w;
	logic [CW-1:0]                    sat_w;
	logic [rpbt_pkg::MUL_A_W-1:0]     mul_a;
	logic [rpbt_pkg::GAIN_W-1:0]      mul_b;
	logic [CW-1:0]                    sat_s1;
	logic [rpbt_pkg::PROD_W-1:0]      prod_s1;
	logic [GT_W-1:0]                  gain_t;
	logic [YT_W-1:0]                  grey_t;

	always_comb begin
		lvl_x = {{(AW-rpbt_pkg::LEVEL_W){ctrl.level[rpbt_pkg::LEVEL_W-1]}}, ctrl.level};
		src_x = $signed({{(AW-CW){1'b0}}, src});
		dst_x = $signed({{(AW-CW){1'b0}}, dst});
		sub_w = src_x - lvl_x;
		sub_pos_w = sub_w[AW-1] ? '0 : sub_w;
		if (ctrl.mode == rpbt_pkg::MODE_BLEND) begin
			add_w = sub_pos_w + dst_x;
		end else begin
			add_w = src_x + lvl_x;
		end
		if (add_w[AW-1]) begin
			sat_w = '0;
		end else if (|add_w[AW-2:CW]) begin
			sat_w = '1;
		end else begin
			sat_w = add_w[CW-1:0];
		end
		if (ctrl.mode == rpbt_pkg::MODE_GREY) begin
			mul_a = sum;
			mul_b = coef;
		end else begin
			mul_a = {{(rpbt_pkg::MUL_A_W-CW){1'b0}}, src};
			mul_b = gain;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sat_s1  <= sat_w;
			prod_s1 <= mul_a * mul_b;
		end
	end

	always_comb begin
		gain_t = prod_s1[rpbt_pkg::PROD_W-1:rpbt_pkg::GAIN_FRAC];
		grey_t = prod_s1[rpbt_pkg::PROD_W-1:rpbt_pkg::GREY_FRAC];
		case (mode_s1)
			rpbt_pkg::MODE_GAIN: chan = (|gain_t[GT_W-1:CW]) ? '1 : gain_t[CW-1:0];
			rpbt_pkg::MODE_GREY: chan = (|grey_t[YT_W-1:CW]) ? '1 : grey_t[CW-1:0];
			default:             chan = sat_s1;
		endcase
	end

endmodule

// File: rtl/core/rpbt_merge.sv
// Merge stage: packs the lane channels into the registered output beat.
module rpbt_merge (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              valid_s1,
	output logic                              ready_s1,
	input  logic [rpbt_pkg::CHAN_W-1:0]       chan [rpbt_pkg::NUM_CH],
	rpbt_out_if.source                        px_out
);

	logic                             valid_s2;
	logic [rpbt_pkg::PIX_W-1:0]       pix_s2;

	assign ready_s1 = !valid_s2 || px_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	// lane 0 is red, in the top byte
	always_ff @(posedge clk) begin
		if (ready_s1 && valid_s1) begin
			pix_s2 <= {chan[0], chan[1], chan[2]};
		end
	end

	assign px_out.valid     = valid_s2;
	assign px_out.out_pixel = pix_s2;

endmodule

// File: rtl/core/rgb_pixel_blend_and_tint_top.sv
// Top level of the RGB pixel blend and tint unit.
// An input beat passes the lane register and then the output register to reach the output.
// Throughput: one pixel per cycle unless stalled; three lanes and merge stage run in step.
// A stalled output holds one result; the lane stage takes a new beat only while empty.
// Reset: pipeline valid bits clear; op_mode = blend, level = 0, gains = 1.0.
// Configuration writes are taken every cycle and apply to beats accepted afterward.
module rgb_pixel_blend_and_tint_top (
	input  logic          clk,
	input  logic          arst_n,
	rpbt_cfg_if.sink      cfg,
	rpbt_in_if.sink       px_in,
	rpbt_out_if.source    px_out
);

	localparam int CW = rpbt_pkg::CHAN_W;
	localparam int NC = rpbt_pkg::NUM_CH;

	rpbt_pkg::rpbt_ctrl_t             ctrl_q;
	logic [rpbt_pkg::GAIN_W-1:0]      gain_q [NC];
	rpbt_pkg::op_mode_t               mode_s1;
	logic                             valid_s1;
	logic                             merge_rdy;
	logic                             load;
	logic [rpbt_pkg::SUM_W-1:0]       sum;
	logic [CW-1:0]                    chan [NC];

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q.mode  <= rpbt_pkg::MODE_BLEND;
			ctrl_q.level <= '0;
			gain_q[0]    <= rpbt_pkg::GAIN_ONE;
			gain_q[1]    <= rpbt_pkg::GAIN_ONE;
			gain_q[2]    <= rpbt_pkg::GAIN_ONE;
		end else if (cfg.valid) begin
			case (cfg.index)
				rpbt_pkg::REG_OP_MODE:    ctrl_q.mode  <= rpbt_pkg::op_mode_t'(cfg.data[1:0]);
				rpbt_pkg::REG_LEVEL:      ctrl_q.level <= cfg.data[rpbt_pkg::LEVEL_W-1:0];
				rpbt_pkg::REG_GAIN_RED:   gain_q[0]    <= cfg.data;
				rpbt_pkg::REG_GAIN_GREEN: gain_q[1]    <= cfg.data;
				rpbt_pkg::REG_GAIN_BLUE:  gain_q[2]    <= cfg.data;
				default: ;
			endcase
		end
	end

	assign px_in.ready = !valid_s1 || merge_rdy;
	assign load = px_in.valid && px_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			mode_s1  <= rpbt_pkg::MODE_BLEND;
		end else if (px_in.ready) begin
			valid_s1 <= px_in.valid;
			mode_s1  <= ctrl_q.mode;
		end
	end

	// grey tint needs R+G+B in every lane
	assign sum = rpbt_pkg::SUM_W'(px_in.src_pixel[23:16])
		+ rpbt_pkg::SUM_W'(px_in.src_pixel[15:8])
		+ rpbt_pkg::SUM_W'(px_in.src_pixel[7:0]);

	for (genvar k = 0; k < NC; k++) begin : g_lane
		rpbt_lane u_lane (
			.clk     (clk),
			.en      (load),
			.ctrl    (ctrl_q),
			.mode_s1 (mode_s1),
			.src     (px_in.src_pixel[CW*(NC-k)-1 -: CW]),
			.dst     (px_in.dest_pixel[CW*(NC-k)-1 -: CW]),
			.sum     (sum),
			.gain    (gain_q[k]),
			.coef    (rpbt_pkg::GREY_COEF[k]),
			.chan    (chan[k])
		);
	end

	rpbt_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.ready_s1 (merge_rdy),
		.chan     (chan),
		.px_out   (px_out)
	);

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> px_in.ready)
		else $error("input stalled with empty lane stage");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !merge_rdy) |=> (valid_s1 && $stable(mode_s1)))
		else $error("lane stage item lost or mode changed during stall");

	a_load_fills: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> valid_s1)
		else $error("accepted beat missing from lane stage");

	a_out_fed: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && merge_rdy) |=> px_out.valid)
		else $error("lane result not moved to output register");

endmodule

// File: tb/rpbt_result_check.sv
// Result checker: tracks register writes, predicts every result pixel and compares it.
module rpbt_result_check
	import rpbt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	rpbt_cfg_if         cfg,
	rpbt_in_if          px_in,
	rpbt_out_if         px_out,
	output int unsigned mismatch_count,
	output int unsigned pending
);

	rpbt_ctrl_t        ctrl;
	logic [GAIN_W-1:0] gain [NUM_CH];
	logic [PIX_W-1:0]  expected_pixels [$];

	// Channel k sits at bits (2-k)*8 +: 8, so k = 0 is red.
	function automatic logic [PIX_W-1:0] blend_tint_pixel(input rpbt_ctrl_t c,
			input logic [GAIN_W-1:0] g [NUM_CH], input logic [PIX_W-1:0] s_px,
			input logic [PIX_W-1:0] d_px);
		logic [CHAN_W-1:0] s_ch [NUM_CH];
		logic [CHAN_W-1:0] d_ch [NUM_CH];
		logic [CHAN_W-1:0] res [NUM_CH];
		int acc;
		int sum;
		sum = 0;
		for (int k = 0; k < NUM_CH; k++) begin
			s_ch[k] = s_px[(2-k)*CHAN_W +: CHAN_W];
			d_ch[k] = d_px[(2-k)*CHAN_W +: CHAN_W];
			sum += int'(s_ch[k]);
		end
		for (int k = 0; k < NUM_CH; k++) begin
			case (c.mode)
				MODE_BLEND: begin
					acc = int'(s_ch[k]) - int'(c.level);
					if (acc < 0)
						acc = 0;
					acc += int'(d_ch[k]);
				end
				MODE_BRIGHT: acc = int'(s_ch[k]) + int'(c.level);
				MODE_GAIN:   acc = (int'(s_ch[k]) * int'(g[k])) >>> GAIN_FRAC;
				default: begin
					// grey tint: exact rationals 3/10, 4/15, 19/30 of the channel sum
					case (k)
						0:       acc = (3 * sum) / 10;
						1:       acc = (4 * sum) / 15;
						default: acc = (19 * sum) / 30;
					endcase
				end
			endcase
			if (acc < 0)
				res[k] = 8'h00;
			else if (acc > 255)
				res[k] = 8'hFF;
			else
				res[k] = acc[CHAN_W-1:0];
		end
		return {res[0], res[1], res[2]};
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		logic [PIX_W-1:0] want;
		if (!arst_n) begin
			ctrl.mode = MODE_BLEND;
			ctrl.level = '0;
			gain = '{default: GAIN_ONE};
			expected_pixels.delete();
			mismatch_count = 0;
			pending = 0;
		end else begin
			if (px_out.valid && px_out.ready) begin
				if (expected_pixels.size() == 0) begin
					$error("out_pixel: expected no beat, got %06h", px_out.out_pixel);
					mismatch_count++;
				end else begin
					want = expected_pixels.pop_front();
					if (px_out.out_pixel !== want) begin
						$error("out_pixel: expected %06h, got %06h", want, px_out.out_pixel);
						mismatch_count++;
					end
				end
			end
			// predict with the settings in force before any write on this edge
			if (px_in.valid && px_in.ready)
				expected_pixels.push_back(blend_tint_pixel(ctrl, gain, px_in.src_pixel,
					px_in.dest_pixel));
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_OP_MODE:    ctrl.mode = op_mode_t'(cfg.data[1:0]);
					REG_LEVEL:      ctrl.level = cfg.data[LEVEL_W-1:0];
					REG_GAIN_RED:   gain[0] = cfg.data;
					REG_GAIN_GREEN: gain[1] = cfg.data;
					REG_GAIN_BLUE:  gain[2] = cfg.data;
					default: ;  // indexes past the register list are dropped
				endcase
			end
			pending = expected_pixels.size();
		end
	end

endmodule

// File: tb/tb.sv
// Top of the pixel unit testbench: clock, reset, register and pixel stimulus, verdict.
module tb;
	import rpbt_pkg::*;

	localparam int NUM_REGS     = 5;
	localparam int QUIET_LIMIT  = 2000;
	localparam int HOLD_CYCLES  = 120;
	localparam int DRAIN_CYCLES = 4;

	logic        clk;
	logic        arst_n;
	int unsigned mismatch_count;
	int unsigned pending_beats;
	int          src_idle_pct = 31;
	int          sink_idle_pct = 31;
	int          quiet_cycles = 0;

	rpbt_cfg_if cfg_ch ();
	rpbt_in_if  in_ch ();
	rpbt_out_if out_ch ();

	rgb_pixel_blend_and_tint_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.px_in  (in_ch),
		.px_out (out_ch)
	);

	rpbt_result_check result_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_ch),
		.px_in          (in_ch),
		.px_out         (out_ch),
		.mismatch_count (mismatch_count),
		.pending        (pending_beats)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Leaves valid high so back-to-back writes need no extra edge; caller lowers it.
	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
	endtask

	task automatic set_regs(input op_mode_t mode, input logic [LEVEL_W-1:0] lvl,
			input logic [GAIN_W-1:0] g_red, input logic [GAIN_W-1:0] g_green,
			input logic [GAIN_W-1:0] g_blue);
		put_reg(REG_OP_MODE, {14'($urandom), mode});
		put_reg(REG_LEVEL, {7'($urandom), lvl});
		put_reg(REG_GAIN_RED, g_red);
		put_reg(REG_GAIN_GREEN, g_green);
		put_reg(REG_GAIN_BLUE, g_blue);
		// a write past the register list must change nothing
		if ($urandom_range(0, 1))
			put_reg(CFG_IDX_W'(NUM_REGS + $urandom_range(0, 2)), 16'($urandom));
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic random_regs(input op_mode_t mode);
		logic [LEVEL_W-1:0] lvl;
		logic [GAIN_W-1:0]  g [NUM_CH];
		case ($urandom_range(0, 7))
			0:       lvl = 9'h0FF;
			1:       lvl = 9'h101;
			2:       lvl = 9'h100;
			3:       lvl = 9'h000;
			default: lvl = 9'($urandom);
		endcase
		for (int k = 0; k < NUM_CH; k++) begin
			case ($urandom_range(0, 7))
				0:       g[k] = 16'h0000;
				1:       g[k] = 16'hFFFF;
				2:       g[k] = GAIN_ONE;
				3, 4, 5: g[k] = 16'($urandom_range(0, 16'h01FF));
				default: g[k] = 16'($urandom);
			endcase
		end
		set_regs(mode, lvl, g[0], g[1], g[2]);
	endtask

	function automatic logic [PIX_W-1:0] random_pixel();
		logic [PIX_W-1:0] px;
		px = 24'($urandom);
		for (int k = 0; k < NUM_CH; k++) begin
			case ($urandom_range(0, 9))
				0:       px[k*CHAN_W +: CHAN_W] = 8'h00;
				1:       px[k*CHAN_W +: CHAN_W] = 8'hFF;
				default: ;
			endcase
		end
		return px;
	endfunction

	task automatic send_beat(input logic [PIX_W-1:0] s_px, input logic [PIX_W-1:0] d_px);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid      <= 1'b1;
		in_ch.src_pixel  <= s_px;
		in_ch.dest_pixel <= d_px;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
	endtask

	// Stop offering, wait for every predicted result, then let the pipe settle.
	task automatic drain();
		in_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_beats != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin : result_sink
		int taken;
		bit held;
		taken = 0;
		held = 0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_ch.valid && out_ch.ready)
				taken++;
			if (!held && taken >= 200) begin
				// long back-pressure so the pipe fills and the input stalls
				held = 1;
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((cfg_ch.valid && cfg_ch.ready) || (in_ch.valid && in_ch.ready) ||
				(out_ch.valid && out_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin : stimulus
		int  n;
		bit  steady;
		arst_n           <= 1'b0;
		cfg_ch.valid     <= 1'b0;
		cfg_ch.index     <= REG_OP_MODE;
		cfg_ch.data      <= '0;
		in_ch.valid      <= 1'b0;
		in_ch.src_pixel  <= '0;
		in_ch.dest_pixel <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: blend with zero level is a plain saturating add
		send_beat(24'h000000, 24'h000000);
		send_beat(24'hFFFFFF, 24'hFFFFFF);
		send_beat(24'h80FF01, 24'h7F01FE);
		drain();
		// gains still at their reset value of 1.0
		put_reg(REG_OP_MODE, {14'd0, MODE_GAIN});
		cfg_ch.valid <= 1'b0;
		send_beat(24'hFF7F01, 24'h000000);
		drain();
		set_regs(MODE_BLEND, 9'h0FF, GAIN_ONE, GAIN_ONE, GAIN_ONE);
		send_beat(24'hFFFFFF, 24'h000000);
		send_beat(24'h123456, 24'hFEDCBA);
		drain();
		// negative level in blend raises the source, here with the most negative raw level
		set_regs(MODE_BLEND, 9'h100, GAIN_ONE, GAIN_ONE, GAIN_ONE);
		send_beat(24'h000000, 24'h000000);
		send_beat(24'hFF00FF, 24'h01FF00);
		drain();
		set_regs(MODE_BRIGHT, 9'h0FF, 16'h0000, 16'h0000, 16'h0000);
		send_beat(24'h000000, 24'hFFFFFF);
		send_beat(24'hFFFFFF, 24'h000000);
		drain();
		set_regs(MODE_BRIGHT, 9'h101, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_beat(24'hFF0001, 24'hFFFFFF);
		drain();
		set_regs(MODE_BRIGHT, 9'h100, GAIN_ONE, GAIN_ONE, GAIN_ONE);
		send_beat(24'hFFFFFF, 24'h000000);
		drain();
		set_regs(MODE_GAIN, 9'h000, 16'h0000, 16'hFFFF, GAIN_ONE);
		send_beat(24'hFFFFFF, 24'h000000);
		send_beat(24'h010101, 24'hFFFFFF);
		drain();
		set_regs(MODE_GAIN, 9'h1FF, 16'h00FF, 16'h0101, 16'h0180);
		send_beat(24'hFFFFFF, 24'h000000);
		drain();
		// grey tint: zero, full white, red alone, and blue either side of saturation
		set_regs(MODE_GREY, 9'h055, 16'h1234, 16'h5678, 16'h9ABC);
		send_beat(24'h000000, 24'hFFFFFF);
		send_beat(24'hFFFFFF, 24'h000000);
		send_beat(24'hFF0000, 24'h000000);
		send_beat(24'h878787, 24'h000000);
		send_beat(24'h868686, 24'h000000);
		drain();

		for (int ph = 0; ph < 10; ph++) begin
			steady = (ph == 4);
			src_idle_pct  = steady ? 0 : 31;
			sink_idle_pct = steady ? 0 : 31;
			random_regs(op_mode_t'(ph % 4));
			n = steady ? 80 : $urandom_range(30, 60);
			repeat (n) send_beat(random_pixel(), random_pixel());
			drain();
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (pending_beats != 0)
			$error("out_pixel: %0d expected beats never arrived", pending_beats);
		if (mismatch_count == 0 && pending_beats == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
